// File: hdl/assert_macros.svh
// Assertion macros used by the port-level checker of the complex ALU.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a clock, disabled while the active-low reset is asserted.
`define CNA_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication built on the macro above.
`define CNA_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
  `CNA_ASSERT(label, clk, rstn, (ante) |-> (cons), msg)

`endif

// File: hdl/cna_pkg.sv
// Package with the types, widths and opcodes of the complex ALU.
package cna_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // Internal widths of the arithmetic datapath.
  localparam int PROD_W  = 2 * DATA_WIDTH;
  localparam int SUM_W   = PROD_W + 1;
  localparam int MAG_W   = SUM_W;
  localparam int DEN_W   = PROD_W;
  localparam int REM_W   = DEN_W;
  localparam int Q_W     = DATA_WIDTH + 1;
  localparam int PRE_W   = SUM_W - FRAC_BITS;
  localparam int LATENCY = Q_W + 5;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CMP  = 3'd4,
    OP_CONJ = 3'd5
  } op_e;

  typedef struct packed {
    logic [2:0]                   opcode;
    logic signed [DATA_WIDTH-1:0] a_re;
    logic signed [DATA_WIDTH-1:0] a_im;
    logic signed [DATA_WIDTH-1:0] b_re;
    logic signed [DATA_WIDTH-1:0] b_im;
  } req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] res_re;
    logic signed [DATA_WIDTH-1:0] res_im;
    logic                         equal;
    logic                         div_by_zero;
    logic                         saturated;
  } rsp_t;

endpackage

// File: hdl/cna_divider.sv
// Pipelined restoring divider: one quotient bit per register stage.
module cna_divider import cna_pkg::*; (
  input  logic             clk_i,
  input  logic [REM_W-1:0] rem_i,
  input  logic [Q_W-1:0]   low_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   quo_o
);

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   low;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   quo;
  } step_t;

  step_t stg_q [Q_W];
  step_t stg_d [Q_W];

  // Each stage shifts in the next dividend bit and subtracts the divisor when it fits.
  always_comb begin
    step_t            src;
    logic [REM_W-1:0] trial;
    logic             ge;
    for (int k = 0; k < Q_W; k++) begin
      if (k == 0) begin
        src.rem = rem_i;
        src.low = low_i;
        src.den = den_i;
        src.quo = '0;
      end else begin
        src = stg_q[k-1];
      end
      trial          = {src.rem[REM_W-2:0], src.low[Q_W-1]};
      ge             = (trial >= src.den);
      stg_d[k].rem   = ge ? (trial - src.den) : trial;
      stg_d[k].low   = {src.low[Q_W-2:0], 1'b0};
      stg_d[k].den   = src.den;
      stg_d[k].quo   = {src.quo[Q_W-2:0], ge};
    end
  end

  // Stage registers carry payload only; validity travels in the parent.
  always_ff @(posedge clk_i) begin
    stg_q <= stg_d;
  end

  assign quo_o = stg_q[Q_W-1].quo;

endmodule

// File: hdl/complex_number_alu_top.sv
// Complex ALU top level: Q16.16 add, subtract, multiply, divide, compare and conjugate.
// Pipeline: input register, products, sums, divider preparation, the 33-stage divider
// (one quotient bit per stage) and the result register, five stages beside the divider.
// Throughput is one word per cycle for every opcode; busy_o stays low.
// Reset clears the valid pipeline only; no result is produced for words lost in reset.
module complex_number_alu_top import cna_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int SH    = Q_W - FRAC_BITS;
  localparam int OVF_W = MAG_W + SH;

  localparam logic signed [PRE_W-1:0] HI =
    $signed({{(PRE_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}});
  localparam logic signed [PRE_W-1:0] LO =
    $signed({{(PRE_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}});

  typedef struct packed {
    logic [2:0]               op;
    logic signed [PROD_W-1:0] p_rr;
    logic signed [PROD_W-1:0] p_ii;
    logic signed [PROD_W-1:0] p_ri;
    logic signed [PROD_W-1:0] p_ir;
    logic signed [PROD_W-1:0] p_br2;
    logic signed [PROD_W-1:0] p_bi2;
    logic signed [PRE_W-1:0]  pre_re;
    logic signed [PRE_W-1:0]  pre_im;
    logic                     eq;
  } prod_t;

  typedef struct packed {
    logic [2:0]              op;
    logic signed [SUM_W-1:0] num_re;
    logic signed [SUM_W-1:0] num_im;
    logic [DEN_W-1:0]        den;
    logic signed [PRE_W-1:0] pre_re;
    logic signed [PRE_W-1:0] pre_im;
    logic                    eq;
  } sum_t;

  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   low;
  } prep_t;

  typedef struct packed {
    logic                    is_div;
    logic                    dz;
    logic                    eq;
    logic                    neg_re;
    logic                    neg_im;
    logic                    ovf_re;
    logic                    ovf_im;
    logic signed [PRE_W-1:0] pre_re;
    logic signed [PRE_W-1:0] pre_im;
  } side_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] val;
    logic                  sat;
  } part_t;

  // Sign, magnitude, overflow test and divider seed for one quotient.
  function automatic prep_t prep_part(input logic signed [SUM_W-1:0] num,
                                      input logic [DEN_W-1:0] den);
    prep_t            r;
    logic [MAG_W-1:0] mag;
    logic [OVF_W-1:0] mag_x;
    logic [OVF_W-1:0] den_x;
    r.neg = num[SUM_W-1];
    mag   = r.neg ? $unsigned(-num) : $unsigned(num);
    mag_x = OVF_W'(mag);
    den_x = OVF_W'({den, {SH{1'b0}}});
    r.ovf = (mag_x >= den_x);
    r.rem = REM_W'(mag >> SH);
    r.low = {mag[SH-1:0], {FRAC_BITS{1'b0}}};
    return r;
  endfunction

  // Clamp a wide signed value to the result range.
  function automatic part_t sat_part(input logic signed [PRE_W-1:0] v);
    part_t r;
    if (v > HI) begin
      r.val = HI[DATA_WIDTH-1:0];
      r.sat = 1'b1;
    end else if (v < LO) begin
      r.val = LO[DATA_WIDTH-1:0];
      r.sat = 1'b1;
    end else begin
      r.val = v[DATA_WIDTH-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  // Signed quotient from its magnitude, with the early overflow decision.
  function automatic part_t div_part(input logic [Q_W-1:0] q, input logic neg,
                                     input logic ovf);
    part_t                   r;
    logic signed [PRE_W-1:0] qpos;
    qpos = $signed(PRE_W'(q));
    if (ovf) begin
      r.val = neg ? LO[DATA_WIDTH-1:0] : HI[DATA_WIDTH-1:0];
      r.sat = 1'b1;
    end else begin
      r = sat_part(neg ? -qpos : qpos);
    end
    return r;
  endfunction

  logic               accept;
  logic [LATENCY-1:0] vld_q;
  req_t               in_q;
  prod_t              s2_d, s2_q;
  sum_t               s3_d, s3_q;
  side_t              s4_side_d, s4_side_q;
  prep_t              prep_re, prep_im;
  logic [REM_W-1:0]   rem_re_q, rem_im_q;
  logic [Q_W-1:0]     low_re_q, low_im_q;
  logic [DEN_W-1:0]   den_q;
  side_t              side_q [Q_W];
  logic [Q_W-1:0]     quo_re, quo_im;
  rsp_t               rsp_d, rsp_q;

  assign accept = start_i && !busy_o;
  assign busy_o = 1'b0;

  // Valid bits march alongside the data, one per register stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LATENCY-2:0], accept};
    end
  end

  // Input word register.
  always_ff @(posedge clk_i) begin
    in_q <= req_i;
  end

  // Products, plus the results that need no multiplier.
  always_comb begin
    logic signed [PRE_W-1:0] ar, ai, br, bi;
    ar = PRE_W'($signed(in_q.a_re));
    ai = PRE_W'($signed(in_q.a_im));
    br = PRE_W'($signed(in_q.b_re));
    bi = PRE_W'($signed(in_q.b_im));
    s2_d.op     = in_q.opcode;
    s2_d.p_rr   = $signed(in_q.a_re) * $signed(in_q.b_re);
    s2_d.p_ii   = $signed(in_q.a_im) * $signed(in_q.b_im);
    s2_d.p_ri   = $signed(in_q.a_re) * $signed(in_q.b_im);
    s2_d.p_ir   = $signed(in_q.a_im) * $signed(in_q.b_re);
    s2_d.p_br2  = $signed(in_q.b_re) * $signed(in_q.b_re);
    s2_d.p_bi2  = $signed(in_q.b_im) * $signed(in_q.b_im);
    s2_d.pre_re = '0;
    s2_d.pre_im = '0;
    s2_d.eq     = 1'b0;
    unique case (op_e'(in_q.opcode))
      OP_ADD: begin
        s2_d.pre_re = ar + br;
        s2_d.pre_im = ai + bi;
      end
      OP_SUB: begin
        s2_d.pre_re = ar - br;
        s2_d.pre_im = ai - bi;
      end
      OP_CMP: begin
        s2_d.eq = (in_q.a_re == in_q.b_re) && (in_q.a_im == in_q.b_im);
      end
      OP_CONJ: begin
        s2_d.pre_re = ar;
        s2_d.pre_im = -ai;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    s2_q <= s2_d;
  end

  // Sums of products: multiply results, divide numerators and the squared magnitude.
  always_comb begin
    logic signed [SUM_W-1:0] mre, mim;
    mre = SUM_W'($signed(s2_q.p_rr)) - SUM_W'($signed(s2_q.p_ii));
    mim = SUM_W'($signed(s2_q.p_ri)) + SUM_W'($signed(s2_q.p_ir));
    s3_d.op     = s2_q.op;
    s3_d.num_re = SUM_W'($signed(s2_q.p_rr)) + SUM_W'($signed(s2_q.p_ii));
    s3_d.num_im = SUM_W'($signed(s2_q.p_ir)) - SUM_W'($signed(s2_q.p_ri));
    s3_d.den    = $unsigned(s2_q.p_br2) + $unsigned(s2_q.p_bi2);
    s3_d.eq     = s2_q.eq;
    if (s2_q.op == OP_MUL) begin
      s3_d.pre_re = PRE_W'(mre >>> FRAC_BITS);
      s3_d.pre_im = PRE_W'(mim >>> FRAC_BITS);
    end else begin
      s3_d.pre_re = s2_q.pre_re;
      s3_d.pre_im = s2_q.pre_im;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_q <= s3_d;
  end

  // Divider preparation: magnitudes, overflow detection and seeds.
  always_comb begin
    prep_re          = prep_part(s3_q.num_re, s3_q.den);
    prep_im          = prep_part(s3_q.num_im, s3_q.den);
    s4_side_d.is_div = (s3_q.op == OP_DIV);
    s4_side_d.dz     = (s3_q.op == OP_DIV) && (s3_q.den == '0);
    s4_side_d.eq     = s3_q.eq;
    s4_side_d.neg_re = prep_re.neg;
    s4_side_d.neg_im = prep_im.neg;
    s4_side_d.ovf_re = prep_re.ovf;
    s4_side_d.ovf_im = prep_im.ovf;
    s4_side_d.pre_re = s3_q.pre_re;
    s4_side_d.pre_im = s3_q.pre_im;
  end

  always_ff @(posedge clk_i) begin
    s4_side_q <= s4_side_d;
    rem_re_q  <= prep_re.rem;
    rem_im_q  <= prep_im.rem;
    low_re_q  <= prep_re.low;
    low_im_q  <= prep_im.low;
    den_q     <= s3_q.den;
  end

  cna_divider u_div_re (
    .clk_i (clk_i),
    .rem_i (rem_re_q),
    .low_i (low_re_q),
    .den_i (den_q),
    .quo_o (quo_re)
  );

  cna_divider u_div_im (
    .clk_i (clk_i),
    .rem_i (rem_im_q),
    .low_i (low_im_q),
    .den_i (den_q),
    .quo_o (quo_im)
  );

  // Side information follows the divider stages.
  always_ff @(posedge clk_i) begin
    side_q[0] <= s4_side_q;
    for (int k = 1; k < Q_W; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  // Result selection and saturation.
  always_comb begin
    side_t sd;
    part_t pr, pi;
    sd = side_q[Q_W-1];
    if (sd.is_div) begin
      pr = div_part(quo_re, sd.neg_re, sd.ovf_re);
      pi = div_part(quo_im, sd.neg_im, sd.ovf_im);
    end else begin
      pr = sat_part(sd.pre_re);
      pi = sat_part(sd.pre_im);
    end
    if (sd.dz) begin
      rsp_d.res_re    = '0;
      rsp_d.res_im    = '0;
      rsp_d.saturated = 1'b0;
    end else begin
      rsp_d.res_re    = pr.val;
      rsp_d.res_im    = pi.val;
      rsp_d.saturated = pr.sat || pi.sat;
    end
    rsp_d.equal       = sd.eq;
    rsp_d.div_by_zero = sd.dz;
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign done_o = vld_q[LATENCY-1];
  assign rsp_o  = rsp_q;

endmodule

// File: hdl/cna_checker.sv
// Port-level checker for the complex ALU, bound to the top level.
`include "assert_macros.svh"

module cna_checker import cna_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input rsp_t rsp_o
);

  // Every accepted word yields its result word on done_o.
  `CNA_ASSERT(a_result_follows, clk_i, rst_ni, start_i && !busy_o |-> ##LATENCY done_o, "result word missing")

  // No result word appears without an accepted word behind it.
  `CNA_ASSERT_IMPL(a_no_spurious, clk_i, rst_ni, done_o, $past(start_i && !busy_o, LATENCY), "spurious result word")

  // A divide by zero reports zero parts and no clamping.
  `CNA_ASSERT_IMPL(a_dz_zero, clk_i, rst_ni, done_o && rsp_o.div_by_zero, rsp_o.res_re == 0 && rsp_o.res_im == 0 && !rsp_o.saturated, "divide by zero result not clean")

endmodule

bind complex_number_alu_top cna_checker u_cna_checker (.*);

// File: tb/complex_number_alu_checker.sv
// Checker for the complex ALU: predicts each accepted word and compares the results.
module complex_number_alu_checker import cna_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic busy_i,
  input  req_t req_i,
  input  logic done_i,
  input  rsp_t rsp_i,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [127:0] MAX_VAL = 128'sd2147483647;
  localparam logic signed [127:0] MIN_VAL = -128'sd2147483648;

  rsp_t expected_rsp_q[$];
  int   fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = expected_rsp_q.size();

  // Clamp a wide value to the data range and note any clamping.
  function automatic logic [31:0] clamp_part(input logic signed [127:0] v, inout logic sat);
    if (v > MAX_VAL) begin
      sat = 1'b1;
      return MAX_VAL[31:0];
    end else if (v < MIN_VAL) begin
      sat = 1'b1;
      return MIN_VAL[31:0];
    end
    return v[31:0];
  endfunction

  // Compute the expected result word for one operand word.
  function automatic rsp_t predict_alu(input req_t rq);
    logic signed [127:0] ar, ai, br, bi, re, im, den;
    logic sat;
    rsp_t r;
    ar  = 128'(signed'(rq.a_re));
    ai  = 128'(signed'(rq.a_im));
    br  = 128'(signed'(rq.b_re));
    bi  = 128'(signed'(rq.b_im));
    re  = '0;
    im  = '0;
    sat = 1'b0;
    r   = '0;
    case (rq.opcode)
      OP_ADD: begin
        re = ar + br;
        im = ai + bi;
      end
      OP_SUB: begin
        re = ar - br;
        im = ai - bi;
      end
      OP_MUL: begin
        re = (ar * br - ai * bi) >>> FRAC_BITS;
        im = (ar * bi + ai * br) >>> FRAC_BITS;
      end
      OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.div_by_zero = 1'b1;
        end else begin
          // Signed division in SystemVerilog truncates toward zero.
          re = ((ar * br + ai * bi) <<< FRAC_BITS) / den;
          im = ((ai * br - ar * bi) <<< FRAC_BITS) / den;
        end
      end
      OP_CMP: r.equal = (rq.a_re == rq.b_re) && (rq.a_im == rq.b_im);
      OP_CONJ: begin
        re = ar;
        im = -ai;
      end
      default: ;
    endcase
    r.res_re    = clamp_part(re, sat);
    r.res_im    = clamp_part(im, sat);
    r.saturated = sat;
    return r;
  endfunction

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Watch both channels at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      fail_count = 0;
      expected_rsp_q.delete();
    end else begin
      if (done_i) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("unexpected word", 64'(rsp_i), 64'd0);
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_i.res_re !== want.res_re)
            report_mismatch("res_re", 64'(rsp_i.res_re), 64'(want.res_re));
          if (rsp_i.res_im !== want.res_im)
            report_mismatch("res_im", 64'(rsp_i.res_im), 64'(want.res_im));
          if (rsp_i.equal !== want.equal)
            report_mismatch("equal", 64'(rsp_i.equal), 64'(want.equal));
          if (rsp_i.div_by_zero !== want.div_by_zero)
            report_mismatch("div_by_zero", 64'(rsp_i.div_by_zero), 64'(want.div_by_zero));
          if (rsp_i.saturated !== want.saturated)
            report_mismatch("saturated", 64'(rsp_i.saturated), 64'(want.saturated));
        end
      end
      if (start_i && !busy_i) expected_rsp_q.push_back(predict_alu(req_i));
    end
  end
endmodule

// File: tb/tb_complex_number_alu_top.sv
// Testbench top for the complex ALU: stimulus, clock, reset and verdict.
module tb_complex_number_alu_top import cna_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  req_t req_i = '0;
  logic busy_o, done_o;
  rsp_t rsp_o;
  int   fail_count, pending;
  int   cycle_count = 0;
  bit   no_idle = 1'b0;

  always #2 clk_i = ~clk_i;

  complex_number_alu_top u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .req_i(req_i),
    .busy_o(busy_o), .done_o(done_o), .rsp_o(rsp_o)
  );

  complex_number_alu_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_i(busy_o),
    .req_i(req_i), .done_i(done_o), .rsp_i(rsp_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("complex_number_alu_top regression: fail");
      $finish;
    end
  end

  // Random operand part that favors edge values.
  function automatic logic [31:0] pick_part();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return 32'($signed($urandom_range(0, 16)) - 8) <<< 16;
      4: return 32'($signed($urandom_range(0, 511)) - 256);
      5: return $urandom & 32'h0003_ffff | ({32{$urandom_range(0, 1) == 1}} & 32'hfffc_0000);
      default: return $urandom;
    endcase
  endfunction

  // Send one word, with random idle cycles ahead of it.
  task automatic send_word(input logic [2:0] op, input logic [31:0] ar, input logic [31:0] ai,
                           input logic [31:0] br, input logic [31:0] bi);
    while (!no_idle && $urandom_range(0, 99) < 31) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= '{opcode: op, a_re: ar, a_im: ai, b_re: br, b_im: bi};
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  initial begin
    logic [31:0] ar, ai;
    logic [2:0]  op;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed words: extremes, every opcode, and the special cases.
    send_word(OP_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff);
    send_word(OP_ADD, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_word(OP_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff);
    send_word(OP_SUB, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000);
    send_word(OP_MUL, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000);
    send_word(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_word(OP_MUL, 32'hffff_ffff, 32'h0, 32'h0000_0001, 32'h0);
    send_word(OP_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0);
    send_word(OP_DIV, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'h0002_0000);
    send_word(OP_DIV, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0001, 32'h0);
    send_word(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_word(OP_DIV, 32'hffff_ffff, 32'h0, 32'h0003_0000, 32'h0);
    send_word(OP_CMP, 32'h1234_5678, 32'h9abc_def0, 32'h1234_5678, 32'h9abc_def0);
    send_word(OP_CMP, 32'h1234_5678, 32'h9abc_def0, 32'h1234_5678, 32'h9abc_def1);
    send_word(OP_CMP, 32'h0, 32'h0, 32'h0, 32'h0);
    send_word(OP_CONJ, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0);
    send_word(OP_CONJ, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_word(3'd6, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_word(3'd7, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'h1);

    // Hold off until every expected word has come back.
    drain_results();

    // Random words; a stretch in the middle runs with no idling.
    for (int i = 0; i < 700; i++) begin
      no_idle = (i >= 300 && i < 400);
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      ar = pick_part();
      ai = pick_part();
      if (op == OP_CMP && $urandom_range(0, 1) == 1) send_word(op, ar, ai, ar, ai);
      else send_word(op, ar, ai, pick_part(), pick_part());
    end

    drain_results();
    if (fail_count == 0) begin
      $display("complex_number_alu_top regression: pass");
    end else begin
      $display("complex_number_alu_top regression: fail");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+hdl
hdl/cna_pkg.sv
hdl/cna_divider.sv
hdl/complex_number_alu_top.sv
hdl/cna_checker.sv
tb/complex_number_alu_checker.sv
tb/tb_complex_number_alu_top.sv
